// File: rtl/polyline_moving_average_smoother_unit_macros.svh
// Assertion helpers for the asserting file of the smoother, its top module.
`ifndef POLYLINE_MOVING_AVERAGE_SMOOTHER_UNIT_MACROS_SVH
`define POLYLINE_MOVING_AVERAGE_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication, quiet in reset.
`define PMAS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoother assertion failed");

// Next-cycle implication, quiet in reset.
`define PMAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoother assertion failed");

`endif

// File: rtl/pmas_pkg.sv
package pmas_pkg;

    // Largest radius the 4-bit register can ask for
    localparam int RADIUS_LIMIT = 15;

    // Register select, taken from paddr[2]
    localparam logic REG_RADIUS = 1'b0;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
        logic               end_of_line;
    } pnt_t;

    typedef struct packed {
        logic signed [31:0] x_avg;
        logic signed [31:0] y_avg;
        logic signed [31:0] z_avg;
        logic [15:0]        point_index;
        logic               last_point;
    } res_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic busy;
    } div_stat_t;

endpackage

// File: rtl/polyline_moving_average_smoother_unit.sv
// Centred moving average over 3D polyline points: each output point is the mean of 2r+1
// consecutive input points, truncated toward zero, so r points are trimmed at each end of a
// line and a line shorter than 2r+1 points gives nothing. s_tlast marks the last point of a
// line and comes back as m_tlast on its result; the line state then returns to empty, as it
// also does on any write to the radius register. A point that gives no result is taken as
// soon as the divider is idle; a point that gives a result holds the back end for the whole
// run of the bit-serial divider, which runs its three coordinate lanes side by side. A
// two-entry queue at the input keeps taking points meanwhile until it is full, and a
// finished result waits in its own output register.
`include "polyline_moving_average_smoother_unit_macros.svh"

module polyline_moving_average_smoother_unit #(
    parameter int MAX_RADIUS  = 15,
    parameter int INDEX_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // x_in, y_in, z_in
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // x_avg, y_avg, z_avg, point_index
    output logic         m_tlast
);
    import pmas_pkg::*;

    localparam int EFF_R      = (MAX_RADIUS < RADIUS_LIMIT) ? MAX_RADIUS : RADIUS_LIMIT;
    localparam int HIST_DEPTH = 2 * EFF_R + 1;
    localparam int SUM_W      = 32 + $clog2(HIST_DEPTH);
    localparam int DIV_W      = $clog2(2 * EFF_R + 2);

    logic                    cfg_wr;
    logic [3:0]              radius_reg;
    logic                    q_valid;
    logic                    q_ready;
    pnt_t                    q_item;
    logic                    job_valid;
    logic                    job_ready;
    logic signed [SUM_W-1:0] job_sum_x;
    logic signed [SUM_W-1:0] job_sum_y;
    logic signed [SUM_W-1:0] job_sum_z;
    logic [DIV_W-1:0]        job_div;
    logic [15:0]             job_index;
    logic                    job_last;
    div_stat_t               div_stat;
    res_t                    res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS);
    assign prdata = (paddr[2] == REG_RADIUS) ? {28'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 4'd0;
        end
        else if (cfg_wr)
        begin
            radius_reg <= pwdata[3:0];
        end
    end

    pmas_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pmas_window #(
        .HIST_DEPTH  (HIST_DEPTH),
        .SUM_W       (SUM_W),
        .DIV_W       (DIV_W),
        .INDEX_WIDTH (INDEX_WIDTH),
        .R_LIMIT     (EFF_R)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_wr),
        .radius    (radius_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_sum_x (job_sum_x),
        .job_sum_y (job_sum_y),
        .job_sum_z (job_sum_z),
        .job_div   (job_div),
        .job_index (job_index),
        .job_last  (job_last)
    );

    pmas_div #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_sum_x (job_sum_x),
        .job_sum_y (job_sum_y),
        .job_sum_z (job_sum_z),
        .job_div   (job_div),
        .job_index (job_index),
        .job_last  (job_last),
        .stat      (div_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.point_index, res.z_avg, res.y_avg, res.x_avg};
    assign m_tlast = res.last_point;

    // A division job is only raised when the divider can take it
    `PMAS_ASSERT_IMPL(a_job_when_ready, job_valid, job_ready)
    // An accepted job keeps the divider busy on the next cycle
    `PMAS_ASSERT_NEXT(a_job_starts_div, job_valid && job_ready, div_stat.busy)
    // A new result only appears out of a finished division
    `PMAS_ASSERT_IMPL(a_result_from_div, $rose(m_tvalid), $past(div_stat.busy))

endmodule

// File: rtl/pmas_front.sv
module pmas_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [95:0]    s_tdata,
    input  logic           s_tlast,
    output logic           q_valid,
    input  logic           q_ready,
    output pmas_pkg::pnt_t q_item
);
    import pmas_pkg::*;

    pnt_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    pnt_t       in_item;

    assign in_item.x_in        = s_tdata[31:0];
    assign in_item.y_in        = s_tdata[63:32];
    assign in_item.z_in        = s_tdata[95:64];
    assign in_item.end_of_line = s_tlast;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/pmas_window.sv
module pmas_window #(
    parameter int HIST_DEPTH  = 31,
    parameter int SUM_W       = 37,
    parameter int DIV_W       = 5,
    parameter int INDEX_WIDTH = 16,
    parameter int R_LIMIT     = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic [3:0]              radius,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  pmas_pkg::pnt_t          q_item,
    output logic                    job_valid,
    input  logic                    job_ready,
    output logic signed [SUM_W-1:0] job_sum_x,
    output logic signed [SUM_W-1:0] job_sum_y,
    output logic signed [SUM_W-1:0] job_sum_z,
    output logic [DIV_W-1:0]        job_div,
    output logic [15:0]             job_index,
    output logic                    job_last
);
    import pmas_pkg::*;

    localparam int HW = $clog2(HIST_DEPTH);

    logic signed [31:0]      hist_reg  [3][HIST_DEPTH];
    logic signed [SUM_W-1:0] sum_reg   [3];
    logic signed [SUM_W-1:0] sum_next  [3];
    logic signed [SUM_W-1:0] old_val   [3];
    logic signed [31:0]      coord     [3];
    logic [DIV_W-1:0]        seen_reg;
    logic [DIV_W-1:0]        seen_next;
    logic [INDEX_WIDTH-1:0]  cnt_reg;
    logic [INDEX_WIDTH-1:0]  cnt_next;
    logic [31:0]             cnt_ext;
    logic [3:0]              r_eff;
    logic [DIV_W-1:0]        w;
    logic [HW-1:0]           tap;
    logic                    full;
    logic [DIV_W:0]          seen_inc;
    logic                    emit;
    logic                    take;

    assign r_eff = (radius > 4'(R_LIMIT)) ? 4'(R_LIMIT) : radius;
    assign w     = DIV_W'({r_eff, 1'b1});
    assign tap   = HW'({r_eff, 1'b0});

    assign coord[0] = q_item.x_in;
    assign coord[1] = q_item.y_in;
    assign coord[2] = q_item.z_in;

    assign full     = (seen_reg >= w);
    assign seen_inc = full ? {1'b0, seen_reg} : {1'b0, seen_reg} + 1'b1;
    assign emit     = (seen_inc >= {1'b0, w});

    // Items that give no result still wait for the divider, keeping order simple
    assign q_ready   = job_ready;
    assign take      = q_valid && job_ready;
    assign job_valid = take && emit;

    assign cnt_ext   = 32'(cnt_reg);
    assign job_index = cnt_ext[15:0];
    assign job_div   = w;
    assign job_last  = q_item.end_of_line;
    assign job_sum_x = sum_next[0];
    assign job_sum_y = sum_next[1];
    assign job_sum_z = sum_next[2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // Drop the point leaving the window once it is full
            old_val[i]  = full ? SUM_W'(hist_reg[i][tap]) : '0;
            sum_next[i] = sum_reg[i] - old_val[i] + SUM_W'(coord[i]);
        end
        seen_next = DIV_W'(seen_inc);
        cnt_next  = (emit && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
            seen_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (clear || (take && q_item.end_of_line))
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
            seen_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entries older than the current line are never read, so the delay line needs no clearing
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hist_reg[i][0] <= coord[i];
                for (int j = 1; j < HIST_DEPTH; j++)
                begin
                    hist_reg[i][j] <= hist_reg[i][j-1];
                end
            end
        end
    end

endmodule

// File: rtl/pmas_div.sv
module pmas_div #(
    parameter int SUM_W = 37,
    parameter int DIV_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  logic signed [SUM_W-1:0] job_sum_x,
    input  logic signed [SUM_W-1:0] job_sum_y,
    input  logic signed [SUM_W-1:0] job_sum_z,
    input  logic [DIV_W-1:0]        job_div,
    input  logic [15:0]             job_index,
    input  logic                    job_last,
    output pmas_pkg::div_stat_t     stat,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output pmas_pkg::res_t          res
);
    import pmas_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    div_state_t       state_reg;
    div_state_t       state_next;
    logic [CW-1:0]    step_reg;
    logic [CW-1:0]    step_next;
    logic [SUM_W-1:0] dvd_reg  [3];
    logic [SUM_W-1:0] dvd_next [3];
    logic [DIV_W-1:0] rem_reg  [3];
    logic [DIV_W-1:0] rem_next [3];
    logic [2:0]       neg_reg;
    logic [2:0]       neg_next;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] div_next;
    logic [15:0]      idx_reg;
    logic [15:0]      idx_next;
    logic             last_reg;
    logic             last_next;
    logic             ovalid_reg;
    logic             ovalid_next;
    res_t             res_reg;
    res_t             res_next;
    logic [DIV_W:0]   rem_sh   [3];
    logic             ge       [3];
    logic [SUM_W-1:0] q_signed [3];

    assign job_ready = (state_reg == DIV_IDLE);
    assign stat.busy = (state_reg != DIV_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign res       = res_reg;

    // One quotient bit per lane and cycle, restoring form
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i]   = {rem_reg[i], dvd_reg[i][SUM_W-1]};
            ge[i]       = (rem_sh[i] >= {1'b0, div_reg});
            q_signed[i] = neg_reg[i] ? -dvd_reg[i] : dvd_reg[i];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        div_next    = div_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        res_next    = res_reg;
        ovalid_next = (ovalid_reg && m_tready) ? 1'b0 : ovalid_reg;

        case (state_reg)
            DIV_IDLE:
            begin
                if (job_valid)
                begin
                    dvd_next[0] = job_sum_x;
                    dvd_next[1] = job_sum_y;
                    dvd_next[2] = job_sum_z;
                    neg_next    = {job_sum_z[SUM_W-1], job_sum_y[SUM_W-1], job_sum_x[SUM_W-1]};
                    div_next    = job_div;
                    idx_next    = job_index;
                    last_next   = job_last;
                    step_next   = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_next[i] = '0;
                    end
                    state_next = DIV_ABS;
                end
            end
            DIV_ABS:
            begin
                // Divide magnitudes; the sign goes back on at the end
                for (int i = 0; i < 3; i++)
                begin
                    dvd_next[i] = neg_reg[i] ? -dvd_reg[i] : dvd_reg[i];
                end
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = ge[i] ? DIV_W'(rem_sh[i] - {1'b0, div_reg})
                                        : DIV_W'(rem_sh[i]);
                    dvd_next[i] = {dvd_reg[i][SUM_W-2:0], ge[i]};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(SUM_W - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                // Hold until the output register is free
                if (!ovalid_reg || m_tready)
                begin
                    res_next.x_avg       = q_signed[0][31:0];
                    res_next.y_avg       = q_signed[1][31:0];
                    res_next.z_avg       = q_signed[2][31:0];
                    res_next.point_index = idx_reg;
                    res_next.last_point  = last_reg;
                    ovalid_next          = 1'b1;
                    state_next           = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= DIV_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        div_reg  <= div_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

endmodule
